// ----- hdl/direct_mapped_key_counter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Direct-mapped key counter: assertion macros
// Shared macros for the concurrent checks on the counter's ports.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_KEY_COUNTER_TOP_DEFINES_SVH
`define DIRECT_MAPPED_KEY_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked only while the block is out of reset.
`define DMKC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define DMKC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/dmkc_pkg.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped key counter package
// Field widths, operation codes and the command and result transaction types.
// ----------------------------------------------------------------------------
package dmkc_pkg;

	localparam int KEY_W   = 64;
	localparam int COUNT_W = 32;

	localparam logic OP_INCREMENT = 1'b0;
	localparam logic OP_READ      = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0]   stored_key;
		logic [COUNT_W-1:0] hit_count;
		logic               collision;
	} result_t;

endpackage

// ----- hdl/dmkc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
module dmkc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/dmkc_queue.sv -----
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples the classifying front end from the table update back end.
// ----------------------------------------------------------------------------
module dmkc_queue #(
	parameter int WIDTH = 75
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/dmkc_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Accepts commands and works out the bucket of each key before queueing it.
// ----------------------------------------------------------------------------
module dmkc_front import dmkc_pkg::*; #(
	parameter int NUM_BUCKETS = 1024,
	parameter int BUCKET_W    = 10,
	parameter int QW          = BUCKET_W + 1 + KEY_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cmd_t          command,
	input  logic          clearing,
	input  logic          q_full,
	output logic          busy,
	output logic          push,
	output logic [QW-1:0] push_data
);

	// A power-of-two table takes the low key bits; any other size reduces the
	// key modulo the table size four bits per cycle, most significant first.
	localparam bit IS_POW2    = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
	localparam int DIGIT_W    = 4;
	localparam int DIGITS     = KEY_W / DIGIT_W;
	localparam int CNT_W      = $clog2(DIGITS);
	localparam logic [BUCKET_W:0] N_EXT = (BUCKET_W + 1)'(NUM_BUCKETS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REDUCE = 2'd1;
	localparam logic [1:0] ST_PUSH   = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    shift_q;
	logic                op_q;
	logic [BUCKET_W-1:0] rem_q;
	logic [BUCKET_W-1:0] rem_next;
	logic                accept;

	assign busy   = (state_q != ST_IDLE) || q_full || clearing;
	assign accept = start && !busy;

	always_comb begin
		logic [BUCKET_W:0]   t;
		logic [BUCKET_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, shift_q[KEY_W-1-i]};
			if (t >= N_EXT) begin
				t = t - N_EXT;
			end
			r = t[BUCKET_W-1:0];
		end
		rem_next = r;
	end

	always_comb begin
		if (IS_POW2) begin
			push      = accept;
			push_data = {command.key[BUCKET_W-1:0], command.operation, command.key};
		end else begin
			push      = (state_q == ST_PUSH) && !q_full;
			push_data = {rem_q, op_q, key_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !IS_POW2) begin
						state_q <= ST_REDUCE;
						cnt_q   <= '0;
					end
				end
				ST_REDUCE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIGITS - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			key_q   <= command.key;
			shift_q <= command.key;
			op_q    <= command.operation;
			rem_q   <= '0;
		end else if (state_q == ST_REDUCE) begin
			shift_q <= shift_q << DIGIT_W;
			rem_q   <= rem_next;
		end
	end

endmodule

// ----- hdl/dmkc_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Clears the table after reset, then runs a read-modify-write per queued item
// with forwarding of the previous write.
// ----------------------------------------------------------------------------
module dmkc_back import dmkc_pkg::*; #(
	parameter int NUM_BUCKETS = 1024,
	parameter int BUCKET_W    = 10,
	parameter int QW          = BUCKET_W + 1 + KEY_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [QW-1:0] q_head,
	output logic          pop,
	output logic          clearing,
	output logic          done,
	output result_t       result
);

	localparam int ENTRY_W = KEY_W + COUNT_W;

	logic                clr_q;
	logic [BUCKET_W-1:0] clr_addr_q;

	logic [BUCKET_W-1:0] bucket_h;

	logic                v_s1;
	logic                op_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [BUCKET_W-1:0] bucket_s1;

	logic                fw_v_q;
	logic [BUCKET_W-1:0] fw_addr_q;
	logic [ENTRY_W-1:0]  fw_data_q;

	logic                done_q;
	result_t             result_q;

	logic [ENTRY_W-1:0]  rdata;
	logic [ENTRY_W-1:0]  entry;
	logic [KEY_W-1:0]    held_key;
	logic [COUNT_W-1:0]  held_cnt;
	logic                clash;
	logic                upd;
	logic [KEY_W-1:0]    new_key;
	logic [COUNT_W-1:0]  new_cnt;
	logic                we;
	logic [BUCKET_W-1:0] waddr;
	logic [ENTRY_W-1:0]  wdata;

	assign bucket_h = q_head[QW-1 -: BUCKET_W];
	assign pop      = q_valid && !clr_q;
	assign clearing = clr_q;

	dmkc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_BUCKETS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (bucket_h),
		.rdata (rdata)
	);

	// The RAM returns old data when the previous item wrote the same bucket on
	// the edge of this read, so that write is forwarded.
	always_comb begin
		entry    = (fw_v_q && fw_addr_q == bucket_s1) ? fw_data_q : rdata;
		held_key = entry[ENTRY_W-1 -: KEY_W];
		held_cnt = entry[COUNT_W-1:0];
		clash    = (op_s1 == OP_INCREMENT) && (held_key != '0) && (held_key != key_s1);
		upd      = v_s1 && (op_s1 == OP_INCREMENT) && !clash;
		new_key  = upd ? key_s1 : held_key;
		new_cnt  = (upd && held_cnt != COUNT_MAX) ? held_cnt + COUNT_W'(1) : held_cnt;
		we       = clr_q || upd;
		waddr    = clr_q ? clr_addr_q : bucket_s1;
		wdata    = clr_q ? '0 : {new_key, new_cnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			v_s1       <= 1'b0;
			fw_v_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				if (clr_addr_q == BUCKET_W'(NUM_BUCKETS - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + BUCKET_W'(1);
				end
			end
			v_s1   <= pop;
			fw_v_q <= upd;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1              <= q_head[KEY_W];
		key_s1             <= q_head[KEY_W-1:0];
		bucket_s1          <= bucket_h;
		fw_addr_q          <= bucket_s1;
		fw_data_q          <= {new_key, new_cnt};
		result_q.stored_key <= new_key;
		result_q.hit_count  <= new_cnt;
		result_q.collision  <= clash;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- hdl/direct_mapped_key_counter_top.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped key counter
// Table of per-key hit counters indexed by the key modulo the table size.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Payload
// -------   --------------------   -------------------------------------
// command   start && !busy         operation, key
// result    done (one-cycle pulse) stored_key, hit_count, collision
//
// After reset the table is cleared one bucket per cycle, which holds busy high
// for the whole sweep; commands are refused until it ends.
// With a power-of-two NUM_BUCKETS the bucket is the low key bits and, once
// the table is cleared, one command is taken every cycle. Any other size
// reduces the key four bits per cycle in the front end, which takes no new
// command until the reduced one has been queued.
// The table's read-modify-write runs once per cycle and forwards its last
// write, so the table RAM sets no limit. Results cannot be held off.
//
module direct_mapped_key_counter_top import dmkc_pkg::*; #(
	parameter int NUM_BUCKETS = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    command,
	output logic    done,
	output result_t result
);

	localparam int BUCKET_W = $clog2(NUM_BUCKETS);
	localparam int QW       = BUCKET_W + 1 + KEY_W;

	// Queue between the front end and the back end. Each entry carries the
	// bucket, the operation and the key of one transaction.
	logic          push;
	logic [QW-1:0] push_data;
	logic          q_full;
	logic          q_valid;
	logic          pop;
	logic [QW-1:0] q_head;

	// High while the back end sweeps the table to zero after reset.
	logic          clearing;

	dmkc_front #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.BUCKET_W    (BUCKET_W),
		.QW          (QW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.clearing  (clearing),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	dmkc_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	// Once the table is cleared, the back end never stalls: it takes one queued
	// transaction per cycle and produces its result on a fixed schedule.
	dmkc_back #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.BUCKET_W    (BUCKET_W),
		.QW          (QW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

// ----- hdl/dmkc_checker.sv -----
// ----------------------------------------------------------------------------
// Direct-mapped key counter port checker
// Checks result consistency and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "direct_mapped_key_counter_top_defines.svh"

module dmkc_checker import dmkc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// A collision means another key already holds the bucket.
	`DMKC_ASSERT_IMPLY(a_collision_has_owner, done && result.collision, result.stored_key != '0, "collision reported on an empty bucket")

	// A key is only stored by an increment, so an owned bucket has counted.
	`DMKC_ASSERT_IMPLY(a_owner_has_count, done && result.stored_key != '0, result.hit_count != '0, "owned bucket shows a zero count")

	// The table sweep keeps commands out right after reset.
	`DMKC_ASSERT_NEXT(a_busy_after_reset, !arst_n, busy, "busy low right after reset")

	// No transaction can complete while reset is applied.
	`DMKC_ASSERT_NEXT(a_no_done_in_reset, !arst_n, !done, "result strobe right after reset")

endmodule

bind direct_mapped_key_counter_top dmkc_checker u_dmkc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ----- tb/sv/direct_mapped_key_counter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direct-mapped key counter testbench
// Sends increment and read commands to the counter and predicts every result
// from its own copy of the bucket store. Each result is compared field by field
// with the oldest prediction. A directed pass covers the corner cases. Random
// passes follow, under several sender gap patterns.
// ----------------------------------------------------------------------------
module direct_mapped_key_counter_top_tb import dmkc_pkg::*;;

	localparam int NUM_BUCKETS    = 1024;
	// The clearing pass after reset sweeps all NUM_BUCKETS buckets with no
	// transaction, so the limit has to sit well above the table size.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_PRINTED    = 100;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    command = '0;
	logic    busy;
	logic    done;
	result_t result;

	// Predicted results, oldest first, one per accepted command.
	result_t pending_results[$];

	// The testbench's own copy of the bucket store.
	logic [KEY_W-1:0]   held_keys   [NUM_BUCKETS];
	logic [COUNT_W-1:0] held_counts [NUM_BUCKETS];

	int mismatch_count = 0;
	int quiet_cycles   = 0;

	direct_mapped_key_counter_top #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.command(command),
		.done   (done),
		.result (result)
	);

	always #2 clk = ~clk;

	// Apply one command to the local store and return the result it must
	// produce. The bucket is the key modulo the table size. An increment
	// claims a bucket that is empty or already holds the same key; a bucket
	// held by any other nonzero key is left as it is and the collision flag
	// is raised. A read never changes anything.
	function automatic result_t count_key(input cmd_t cmd);
		int      idx;
		result_t res;
		idx = int'(cmd.key % NUM_BUCKETS);
		res.collision = 1'b0;
		if (cmd.operation == OP_INCREMENT) begin
			if (held_keys[idx] != '0 && held_keys[idx] != cmd.key) begin
				res.collision = 1'b1;
			end else begin
				held_keys[idx] = cmd.key;
				if (held_counts[idx] != COUNT_MAX)
					held_counts[idx] = held_counts[idx] + COUNT_W'(1);
			end
		end
		res.stored_key = held_keys[idx];
		res.hit_count  = held_counts[idx];
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("%0t ns: %s mismatch: got 0x%0h, predicted 0x%0h",
				$realtime, field, got, want);
		mismatch_count++;
	endtask

	// Check every result in the cycle its strobe is up. Values are sampled at
	// the rising edge, before the block's registers move on.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested result, stored_key", result.stored_key, '0);
			end else begin
				want = pending_results.pop_front();
				if (result.stored_key !== want.stored_key)
					report_mismatch("stored_key", result.stored_key, want.stored_key);
				if (result.hit_count !== want.hit_count)
					report_mismatch("hit_count", KEY_W'(result.hit_count),
						KEY_W'(want.hit_count));
				if (result.collision !== want.collision)
					report_mismatch("collision", KEY_W'(result.collision),
						KEY_W'(want.collision));
			end
		end
	end

	// Watchdog: any cycle in which neither a command nor a result transaction
	// completes counts toward the limit.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Send one command. The task is entered at a rising edge and returns at
	// the edge where the block accepted the command, with start still high so
	// that back-to-back commands need no extra cycle. The gap before the
	// command is geometric: each cycle idles with the given percentage.
	task automatic send_command(input logic op, input logic [KEY_W-1:0] key,
			input int idle_pct);
		int   gap;
		cmd_t cmd;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.operation = op;
		cmd.key       = key;
		start   <= 1'b1;
		command <= cmd;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_results.push_back(count_key(cmd));
	endtask

	// Hold the sender off until every predicted result has come back.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Directed corner cases, sent back to back. The saturated count cannot be
	// reached here, since it would take 2^32 - 1 increments of one bucket.
	task automatic test_corner_cases();
		// Read of a bucket nobody has touched.
		send_command(OP_READ, 64'd5, 0);
		// Key zero counts in bucket 0 but leaves it unoccupied.
		send_command(OP_INCREMENT, 64'd0, 0);
		send_command(OP_INCREMENT, 64'd0, 0);
		send_command(OP_READ, 64'd0, 0);
		// A nonzero key claims bucket 0 and continues from the count there.
		send_command(OP_INCREMENT, 64'd1024, 0);
		// Different key, same bucket: collision, entry unchanged.
		send_command(OP_INCREMENT, 64'd2048, 0);
		send_command(OP_READ, 64'd2048, 0);
		// Key zero against an occupied bucket is a collision as well.
		send_command(OP_INCREMENT, 64'd0, 0);
		// Extremes of the key field.
		send_command(OP_INCREMENT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_command(OP_INCREMENT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_command(OP_INCREMENT, 64'h7FFF_FFFF_FFFF_FFFF, 0);
		send_command(OP_INCREMENT, 64'h8000_0000_0000_0000, 0);
		send_command(OP_INCREMENT, 64'h8000_0000_0000_0001, 0);
		send_command(OP_READ, 64'd1, 0);
		send_command(OP_INCREMENT, 64'hAAAA_AAAA_AAAA_AAAA, 0);
		send_command(OP_INCREMENT, 64'h5555_5555_5555_5555, 0);
		send_command(OP_READ, 64'd1023, 0);
		// Back-to-back increments of one key lean on the write forwarding.
		repeat (4) send_command(OP_INCREMENT, 64'd7, 0);
		send_command(OP_READ, 64'd7, 0);
		drain_results();
	endtask

	// Random commands. Most keys fall in a few hot buckets with a few high
	// parts, so counts grow and collisions are frequent; the rest are fully
	// random keys that exercise every key bit. Now and then the sender drains
	// the pipeline before going on.
	task automatic test_random_traffic(input int num_cmds, input int idle_pct);
		logic [KEY_W-11:0] tag_pool [4];
		logic [9:0]        bucket;
		logic [KEY_W-1:0]  key;
		logic              op;
		int                mode;
		tag_pool[0] = '0;
		tag_pool[1] = 54'd1;
		tag_pool[2] = 54'({$urandom, $urandom});
		tag_pool[3] = 54'({$urandom, $urandom});
		for (int i = 0; i < num_cmds; i++) begin
			mode   = $urandom_range(9);
			bucket = $urandom_range(1) ? 10'($urandom_range(7))
				: 10'(NUM_BUCKETS - 1 - $urandom_range(7));
			if (mode <= 5)
				key = {tag_pool[$urandom_range(3)], bucket};
			else if (mode <= 8)
				key = {$urandom, $urandom};
			else
				key = {54'd0, bucket};
			op = ($urandom_range(3) == 0) ? OP_READ : OP_INCREMENT;
			send_command(op, key, idle_pct);
			if (i % 97 == 96 && $urandom_range(1) == 1)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			held_keys[i]   = '0;
			held_counts[i] = '0;
		end
		// Reset is applied once; the block then clears its store, holding
		// busy high, which the first send simply waits out.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_traffic(335, 0);
		test_random_traffic(335, 81);
		test_random_traffic(335, 11);
		test_random_traffic(335, 0);

		// Let any stray late result show up before the verdict.
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/dmkc_pkg.sv
hdl/dmkc_ram.sv
hdl/dmkc_queue.sv
hdl/dmkc_front.sv
hdl/dmkc_back.sv
hdl/direct_mapped_key_counter_top.sv
hdl/dmkc_checker.sv
tb/sv/direct_mapped_key_counter_top_tb.sv
